// File: rtl/best_fit_block_allocator_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the best-fit block allocator
// Concurrent checks clocked on i_clk and disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BEST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

`ifndef SYNTH
`define BFBA_ASSERT(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);
`define BFBA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BFBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BFBA_ASSERT(label, cond, msg)
`define BFBA_ASSERT_IMPL(label, ante, cons, msg)
`define BFBA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: rtl/bfba_pkg.sv
// ---------------------------------------------------------------------------
// Best-fit block allocator package
// Beat types, internal command format and fixed constants.
// ---------------------------------------------------------------------------
package bfba_pkg;

    localparam int IDX_FIELD_W  = 4;
    localparam int SIZE_FIELD_W = 16;
    localparam int REQ_NUM_W    = 16;
    localparam int ACTIVE_W     = 5;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic                CMD_LOAD          = 1'b0;
    localparam logic                CMD_REQUEST       = 1'b1;
    localparam logic                REG_ACTIVE_BLOCKS = 1'b0;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET      = 5'd16;

    typedef struct packed {
        logic                    cmd;
        logic [IDX_FIELD_W-1:0]  block_index;
        logic [SIZE_FIELD_W-1:0] size;
        logic                    final_request;
    } t_in_item;

    typedef struct packed {
        logic [REQ_NUM_W-1:0]    request_number;
        logic                    granted;
        logic [IDX_FIELD_W-1:0]  chosen_block;
        logic [SIZE_FIELD_W-1:0] left_size;
    } t_out_item;

    // Work handed from the front end to the execution side.
    typedef struct packed {
        logic                    is_req;
        logic [IDX_FIELD_W-1:0]  index;
        logic [SIZE_FIELD_W-1:0] size;
        logic [REQ_NUM_W-1:0]    req_num;
    } t_cmd;

endpackage

// File: rtl/bfba_front.sv
// ---------------------------------------------------------------------------
// Best-fit block allocator front end
// Accepts input beats, drops loads outside the active range and numbers
// requests within their batch.
// ---------------------------------------------------------------------------
module bfba_front #(
    parameter int CNT_W = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CNT_W-1:0]  i_act,
    input  logic              i_in_valid,
    input  bfba_pkg::t_in_item i_in,
    output logic              o_in_stall,
    input  logic              i_q_full,
    output logic              o_push,
    output bfba_pkg::t_cmd    o_push_data
);

    localparam int CW = (CNT_W > bfba_pkg::IDX_FIELD_W) ? CNT_W : bfba_pkg::IDX_FIELD_W;

    logic [bfba_pkg::REQ_NUM_W-1:0] r_req_count;
    logic [bfba_pkg::REQ_NUM_W-1:0] n_req_count;
    logic                           w_accept;
    logic                           w_is_req;
    logic                           w_in_range;

    assign o_in_stall = i_q_full;
    assign w_accept   = i_in_valid && !i_q_full;
    assign w_is_req   = (i_in.cmd == bfba_pkg::CMD_REQUEST);
    assign w_in_range = CW'(i_in.block_index) < CW'(i_act);

    assign o_push              = w_accept && (w_is_req || w_in_range);
    assign o_push_data.is_req  = w_is_req;
    assign o_push_data.index   = i_in.block_index;
    assign o_push_data.size    = i_in.size;
    assign o_push_data.req_num = r_req_count;

    always_comb begin
        n_req_count = r_req_count;
        if (w_accept && w_is_req) begin
            n_req_count = i_in.final_request ? '0 : r_req_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_count <= '0;
        end else begin
            r_req_count <= n_req_count;
        end
    end

endmodule

// File: rtl/bfba_queue.sv
// ---------------------------------------------------------------------------
// Best-fit block allocator command queue
// Short FIFO between the front end and the execution side.
// ---------------------------------------------------------------------------
module bfba_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bfba_pkg::t_cmd i_push_data,
    output logic           o_full,
    output logic           o_valid,
    output bfba_pkg::t_cmd o_data,
    input  logic           i_pop
);

    localparam int PTR_W = (bfba_pkg::QUEUE_DEPTH > 1) ? $clog2(bfba_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(bfba_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(bfba_pkg::QUEUE_DEPTH - 1);

    bfba_pkg::t_cmd   r_mem [bfba_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(bfba_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/bfba_back.sv
// ---------------------------------------------------------------------------
// Best-fit block allocator execution side
// Holds the free-size table, scans it one entry per cycle for a request and
// writes the remainder back, then presents the result beat.
// ---------------------------------------------------------------------------
`include "best_fit_block_allocator_assert.svh"

module bfba_back #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [$clog2(NUM_BLOCKS+1)-1:0]     i_act,
    input  logic                                i_q_valid,
    input  bfba_pkg::t_cmd                      i_q_data,
    output logic                                o_q_pop,
    output logic                                o_out_valid,
    output bfba_pkg::t_out_item                 o_out,
    input  logic                                i_out_stall
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE
    } t_state;

    t_state                         r_state;
    logic [SIZE_BITS-1:0]           r_mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0]          r_vbit;
    logic [CNT_W-1:0]               r_addr;
    logic                           r_cmp_go;
    logic [IDX_W-1:0]               r_cmp_idx;
    logic [SIZE_BITS-1:0]           r_rd_data;
    logic                           r_rd_ok;
    logic [SIZE_BITS-1:0]           r_size;
    logic [bfba_pkg::REQ_NUM_W-1:0] r_req_num;
    logic                           r_found;
    logic [SIZE_BITS-1:0]           r_best_val;
    logic [IDX_W-1:0]               r_best_idx;
    logic                           r_out_valid;
    bfba_pkg::t_out_item            r_out;

    logic                 w_issue;
    logic [SIZE_BITS-1:0] w_entry;
    logic                 w_better;
    logic                 w_out_free;
    logic [SIZE_BITS-1:0] w_left;
    logic                 w_load;
    logic                 w_we;
    logic [IDX_W-1:0]     w_waddr;
    logic [SIZE_BITS-1:0] w_wdata;

    assign w_issue    = (r_state == S_SCAN) && (r_addr < i_act);
    // An entry never written since reset reads as zero.
    assign w_entry    = r_rd_ok ? r_rd_data : '0;
    assign w_better   = r_cmp_go && (w_entry >= r_size) && (!r_found || (w_entry < r_best_val));
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_left     = r_best_val - r_size;

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign w_load  = o_q_pop && !i_q_data.is_req;
    // Holding in S_WRITE rewrites the same value, which is harmless.
    assign w_we    = w_load || ((r_state == S_WRITE) && r_found);
    assign w_waddr = w_load ? IDX_W'(i_q_data.index) : r_best_idx;
    assign w_wdata = w_load ? SIZE_BITS'(i_q_data.size) : w_left;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_issue) begin
            r_rd_data <= r_mem[r_addr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vbit      <= '0;
            r_cmp_go    <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_we) begin
                r_vbit[w_waddr] <= 1'b1;
            end
            if ((r_state == S_WRITE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_q_pop && i_q_data.is_req) begin
                        r_size    <= SIZE_BITS'(i_q_data.size);
                        r_req_num <= i_q_data.req_num;
                        r_found   <= 1'b0;
                        r_addr    <= '0;
                        r_cmp_go  <= 1'b0;
                        r_state   <= (i_act == '0) ? S_WRITE : S_SCAN;
                    end
                end
                S_SCAN: begin
                    // Read of one entry overlaps the compare of the previous one.
                    r_cmp_go <= w_issue;
                    if (w_issue) begin
                        r_rd_ok   <= r_vbit[r_addr[IDX_W-1:0]];
                        r_cmp_idx <= r_addr[IDX_W-1:0];
                        r_addr    <= r_addr + 1'b1;
                    end
                    if (w_better) begin
                        r_found    <= 1'b1;
                        r_best_val <= w_entry;
                        r_best_idx <= r_cmp_idx;
                    end
                    if (!w_issue && r_cmp_go) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (w_out_free) begin
                        r_out.request_number <= r_req_num;
                        r_out.granted        <= r_found;
                        r_out.chosen_block   <= r_found ? bfba_pkg::IDX_FIELD_W'(r_best_idx) : '0;
                        r_out.left_size      <= r_found ? bfba_pkg::SIZE_FIELD_W'(w_left) : '0;
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `BFBA_ASSERT_IMPL(a_best_fits, r_found, r_best_val >= r_size, "best entry smaller than request")
    `BFBA_ASSERT_NEXT(a_req_leaves_idle, o_q_pop && i_q_data.is_req, r_state != S_IDLE, "request did not start")
    `BFBA_ASSERT_IMPL(a_pop_has_data, o_q_pop, i_q_valid, "pop from empty queue")
    `BFBA_ASSERT_IMPL(a_denied_zero, r_out_valid && !r_out.granted, (r_out.chosen_block == '0) && (r_out.left_size == '0), "denied result carries data")

endmodule

// File: rtl/best_fit_block_allocator.sv
// A request goes from the command queue through the idle state that pops it, a table scan
// over the effective active block count (skipped when that is zero) and the write state,
// which loads the output register once it is free. No command is popped before that; the
// scan reads one entry per cycle. A load is written when popped, and loads retire one per
// cycle while no request is in progress. A two-entry queue decouples input. Reset: synchronous,
// active low; table valid bits and the request counter clear, active_blocks returns to 16.
// ---------------------------------------------------------------------------
// Best-fit block allocator
// Free-size table with best-fit allocation, APB register for the active count.
// ---------------------------------------------------------------------------
module best_fit_block_allocator #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  bfba_pkg::t_in_item                  i_in,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output bfba_pkg::t_out_item                 o_out,
    input  logic                                i_out_stall,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bfba_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bfba_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bfba_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int CMP_W = (CNT_W > bfba_pkg::ACTIVE_W) ? CNT_W : bfba_pkg::ACTIVE_W;

    logic [bfba_pkg::ACTIVE_W-1:0] r_active_blocks;
    logic [CMP_W-1:0]              w_act_wide;
    logic [CNT_W-1:0]              w_act;
    logic                          w_cfg_write;
    logic                          w_q_full;
    logic                          w_push;
    bfba_pkg::t_cmd                w_push_data;
    logic                          w_q_valid;
    bfba_pkg::t_cmd                w_q_data;
    logic                          w_q_pop;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign prdata      = (paddr[2] == bfba_pkg::REG_ACTIVE_BLOCKS)
                         ? bfba_pkg::APB_DATA_W'(r_active_blocks) : '0;

    // Counts above the table size act as the table size.
    assign w_act_wide = (CMP_W'(r_active_blocks) > CMP_W'(NUM_BLOCKS))
                        ? CMP_W'(NUM_BLOCKS) : CMP_W'(r_active_blocks);
    assign w_act      = CNT_W'(w_act_wide);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_blocks <= bfba_pkg::ACTIVE_RESET;
        end else if (w_cfg_write && (paddr[2] == bfba_pkg::REG_ACTIVE_BLOCKS)) begin
            r_active_blocks <= pwdata[bfba_pkg::ACTIVE_W-1:0];
        end
    end

    bfba_front #(
        .CNT_W (CNT_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_act       (w_act),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    bfba_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_q_full),
        .o_valid     (w_q_valid),
        .o_data      (w_q_data),
        .i_pop       (w_q_pop)
    );

    bfba_back #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_act       (w_act),
        .i_q_valid   (w_q_valid),
        .i_q_data    (w_q_data),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

endmodule

// File: sim/best_fit_block_allocator_tb.sv
// ---------------------------------------------------------------------------
// Best-fit block allocator testbench
// Drives load and request beats with random gaps and output stalls, predicts
// every result from its own copy of the free-size table, and compares the
// result beats in order. Also covers the active_blocks register, back pressure
// and a long batch of requests.
// ---------------------------------------------------------------------------
module best_fit_block_allocator_tb;

    localparam int NUM_BLOCKS   = 16;
    localparam int REG_SPARE    = 1;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int LONG_BATCH   = 40;
    localparam int RANDOM_BEATS = 1300;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    bfba_pkg::t_in_item              i_in;
    logic                            o_in_stall;
    logic                            o_out_valid;
    bfba_pkg::t_out_item             o_out;
    logic                            i_out_stall;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [bfba_pkg::APB_ADDR_W-1:0] paddr;
    logic [bfba_pkg::APB_DATA_W-1:0] pwdata;
    logic [bfba_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    // Predicted block state and configuration.
    logic [bfba_pkg::SIZE_FIELD_W-1:0] free_size [NUM_BLOCKS];
    logic [bfba_pkg::REQ_NUM_W-1:0]    batch_seq;
    logic [bfba_pkg::ACTIVE_W-1:0]     active_cfg;
    bfba_pkg::t_out_item               pending_grants [$];

    int  useful_beats;
    int  mismatch_count;
    bit  tx_no_gaps;
    bit  rx_no_stall;
    bit  hold_request;
    int  hold_count;
    int  rx_run;
    bit  rx_stalling;

    best_fit_block_allocator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40000000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic note_error(input string msg);
        mismatch_count++;
        $display("%s", msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
            note_error($sformatf("%0t: %s expected %0h got %0h", $time, name, want, got));
    endtask

    function automatic int live_blocks();
        return (active_cfg > NUM_BLOCKS) ? NUM_BLOCKS : int'(active_cfg);
    endfunction

    function automatic bfba_pkg::t_in_item make_load(input logic [3:0] idx,
                                                     input logic [15:0] sz,
                                                     input logic is_last);
        bfba_pkg::t_in_item beat;
        beat.cmd           = bfba_pkg::CMD_LOAD;
        beat.block_index   = idx;
        beat.size          = sz;
        beat.final_request = is_last;
        return beat;
    endfunction

    function automatic bfba_pkg::t_in_item make_request(input logic [15:0] sz,
                                                        input logic is_last);
        bfba_pkg::t_in_item beat;
        beat.cmd           = bfba_pkg::CMD_REQUEST;
        beat.block_index   = 4'($urandom);
        beat.size          = sz;
        beat.final_request = is_last;
        return beat;
    endfunction

    // Best fit: smallest free size that holds the request, lowest index on ties.
    task automatic predict_beat(input bfba_pkg::t_in_item beat);
        int                  act;
        int                  best;
        bit                  found;
        bfba_pkg::t_out_item res;
        act = live_blocks();
        if (beat.cmd == bfba_pkg::CMD_LOAD) begin
            if (beat.block_index < act) begin
                free_size[beat.block_index] = beat.size;
                useful_beats++;
            end
            return;
        end
        found = 1'b0;
        best  = 0;
        for (int j = 0; j < act; j++) begin
            if (free_size[j] >= beat.size && (!found || free_size[j] < free_size[best])) begin
                best  = j;
                found = 1'b1;
            end
        end
        res.request_number = batch_seq;
        res.granted        = found;
        res.chosen_block   = found ? best[3:0] : '0;
        res.left_size      = '0;
        if (found) begin
            free_size[best] = free_size[best] - beat.size;
            res.left_size   = free_size[best];
        end
        pending_grants.push_back(res);
        batch_seq = beat.final_request ? '0 : batch_seq + 1'b1;
        useful_beats++;
    endtask

    function automatic int idle_gap();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Every task below starts and ends just after a falling edge.
    task automatic send_beat(input bfba_pkg::t_in_item beat);
        int gap;
        gap = (tx_no_gaps || $urandom_range(0, 1) == 0) ? 0 : idle_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in       <= beat;
        i_in_valid <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        predict_beat(beat);
        @(negedge i_clk);
    endtask

    // Loads leave no result behind, so a short pause covers any still in flight.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_grants.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_transfer(input bit is_write, input int reg_index,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= bfba_pkg::APB_ADDR_W'(reg_index * 4);
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready) break;
        end
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_register(input int reg_index, input logic [31:0] value);
        logic [31:0] rdata;
        wait_idle();
        apb_transfer(1'b1, reg_index, value, rdata);
        if (reg_index == bfba_pkg::REG_ACTIVE_BLOCKS)
            active_cfg = value[bfba_pkg::ACTIVE_W-1:0];
        apb_transfer(1'b0, bfba_pkg::REG_ACTIVE_BLOCKS, '0, rdata);
        check_field("active_blocks readback", 16'(active_cfg),
                    16'(rdata[bfba_pkg::ACTIVE_W-1:0]));
    endtask

    function automatic logic [15:0] random_free_size();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(0, 15));
            1: return 16'($urandom_range(0, 8) * 1000);
            2: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] random_request_size();
        int act;
        int pick;
        act = live_blocks();
        pick = $urandom_range(0, 9);
        if (act > 0 && pick <= 3) return free_size[$urandom_range(0, act - 1)];
        if (act > 0 && pick == 8) return free_size[$urandom_range(0, act - 1)] + 1'b1;
        case (pick)
            4: return '0;
            5, 6: return 16'($urandom_range(0, 15));
            7: return 16'($urandom_range(0, 8000));
            default: return 16'($urandom);
        endcase
    endfunction

    // Receiver: random stall runs, quiet stretches, and a long counted hold-off.
    always @(negedge i_clk) begin
        if (hold_request) begin
            i_out_stall <= 1'b1;
            hold_count++;
            if (hold_count >= HOLD_CYCLES) begin
                hold_request = 1'b0;
                hold_count   = 0;
            end
        end else if (rx_no_stall) begin
            i_out_stall <= 1'b0;
        end else begin
            if (rx_run == 0) begin
                rx_stalling = ($urandom_range(0, 2) == 0);
                rx_run      = rx_stalling ? idle_gap() : $urandom_range(1, 24);
            end
            i_out_stall <= rx_stalling;
            rx_run--;
        end
    end

    always @(posedge i_clk) begin
        bfba_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_grants.size() == 0) begin
                note_error($sformatf("%0t: result beat expected none got %0h", $time, o_out));
            end else begin
                want = pending_grants.pop_front();
                check_field("request_number", want.request_number, o_out.request_number);
                check_field("granted", 16'(want.granted), 16'(o_out.granted));
                check_field("chosen_block", 16'(want.chosen_block), 16'(o_out.chosen_block));
                check_field("left_size", want.left_size, o_out.left_size);
            end
        end
    end

    task automatic test_reset_table();
        // After reset every block reads as zero: only a zero-size request fits.
        send_beat(make_request(16'h0000, 1'b0));
        send_beat(make_request(16'h0001, 1'b0));
        send_beat(make_request(16'hFFFF, 1'b1));
    endtask

    task automatic test_best_fit_order();
        send_beat(make_load(4'd15, 16'hFFFF, 1'b0));
        send_beat(make_load(4'd0, 16'd100, 1'b0));
        send_beat(make_load(4'd3, 16'd100, 1'b0));
        send_beat(make_load(4'd7, 16'd50, 1'b0));
        // The final flag on a load must not touch the request counter.
        send_beat(make_load(4'd1, 16'hFFFF, 1'b1));
        send_beat(make_request(16'd60, 1'b0));
        send_beat(make_request(16'd50, 1'b0));
        send_beat(make_request(16'd100, 1'b0));
        send_beat(make_request(16'd0, 1'b0));
        send_beat(make_request(16'hFFFF, 1'b1));
    endtask

    task automatic test_active_count();
        write_register(bfba_pkg::REG_ACTIVE_BLOCKS, 32'd2);
        send_beat(make_load(4'd5, 16'd10, 1'b0));
        send_beat(make_load(4'd1, 16'd30, 1'b0));
        send_beat(make_request(16'd20, 1'b0));
        write_register(bfba_pkg::REG_ACTIVE_BLOCKS, 32'd0);
        send_beat(make_load(4'd0, 16'd500, 1'b0));
        send_beat(make_request(16'd0, 1'b1));
        write_register(bfba_pkg::REG_ACTIVE_BLOCKS, 32'd31);
        send_beat(make_request(16'd1, 1'b0));
        write_register(REG_SPARE, 32'd3);
        send_beat(make_request(16'd1, 1'b1));
        // Upper data bits are outside the register and must be dropped.
        write_register(bfba_pkg::REG_ACTIVE_BLOCKS, 32'hFFFF_FFF0);
    endtask

    task automatic test_full_backpressure();
        write_register(bfba_pkg::REG_ACTIVE_BLOCKS, 32'd16);
        tx_no_gaps   = 1'b1;
        hold_request = 1'b1;
        for (int i = 0; i < 24; i++) begin
            if (i % 3 == 0) send_beat(make_load(4'($urandom), random_free_size(), 1'b0));
            else send_beat(make_request(random_request_size(), 1'b0));
        end
        wait_idle();
        tx_no_gaps = 1'b0;
    endtask

    task automatic test_long_batch();
        write_register(bfba_pkg::REG_ACTIVE_BLOCKS, 32'd1);
        tx_no_gaps  = 1'b1;
        rx_no_stall = 1'b1;
        send_beat(make_load(4'd0, 16'hFFFF, 1'b0));
        repeat (LONG_BATCH) send_beat(make_request(16'd0, 1'b0));
        send_beat(make_request(16'd1, 1'b1));
        wait_idle();
        tx_no_gaps  = 1'b0;
        rx_no_stall = 1'b0;
    endtask

    task automatic run_batch();
        int act;
        int n_req;
        act = live_blocks();
        if ($urandom_range(0, 4) != 0) begin
            for (int i = 0; i < NUM_BLOCKS; i++) begin
                if ($urandom_range(0, 3) != 0 && (i < act || $urandom_range(0, 4) == 0))
                    send_beat(make_load(4'(i), random_free_size(), 1'($urandom)));
            end
        end
        n_req = $urandom_range(1, 10);
        for (int k = 0; k < n_req; k++) begin
            if ($urandom_range(0, 9) == 0)
                send_beat(make_load(4'($urandom), random_free_size(), 1'($urandom)));
            if (k == n_req - 1)
                send_beat(make_request(random_request_size(), $urandom_range(0, 9) != 0));
            else
                send_beat(make_request(random_request_size(), $urandom_range(0, 19) == 0));
        end
    endtask

    task automatic test_random_traffic();
        int          target;
        int          phase_end;
        logic [31:0] cfg;
        target = useful_beats + RANDOM_BEATS;
        for (int phase = 0; useful_beats < target; phase++) begin
            case (phase)
                0: cfg = 32'd16;
                1: cfg = 32'd1;
                2: cfg = 32'd0;
                3: cfg = 32'd31;
                4: cfg = 32'd17;
                default: cfg = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                           : $urandom_range(1, 16);
            endcase
            if ($urandom_range(0, 3) == 0)
                cfg[31:bfba_pkg::ACTIVE_W] = (32 - bfba_pkg::ACTIVE_W)'($urandom);
            write_register(bfba_pkg::REG_ACTIVE_BLOCKS, cfg);
            if ($urandom_range(0, 4) == 0) write_register(REG_SPARE, $urandom);
            tx_no_gaps  = ($urandom_range(0, 3) == 0);
            rx_no_stall = ($urandom_range(0, 3) == 0);
            phase_end   = useful_beats + 150;
            while (useful_beats < phase_end) run_batch();
        end
        tx_no_gaps  = 1'b0;
        rx_no_stall = 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_out_stall = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        for (int i = 0; i < NUM_BLOCKS; i++) free_size[i] = '0;
        batch_seq      = '0;
        active_cfg     = bfba_pkg::ACTIVE_RESET;
        useful_beats   = 0;
        mismatch_count = 0;
        tx_no_gaps     = 1'b0;
        rx_no_stall    = 1'b0;
        hold_request   = 1'b0;
        hold_count     = 0;
        rx_run         = 0;
        rx_stalling    = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_table();
        test_best_fit_order();
        test_active_count();
        test_full_backpressure();
        test_long_batch();
        test_random_traffic();

        wait_idle();
        if (mismatch_count == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/bfba_pkg.sv
rtl/bfba_front.sv
rtl/bfba_queue.sv
rtl/bfba_back.sv
rtl/best_fit_block_allocator.sv
sim/best_fit_block_allocator_tb.sv
